// ===== rtl/lkvc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared constants and types for the LRU key-value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

  localparam int ENTRIES   = 16;
  localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int AGE_W     = IDX_W;
  localparam int CNT_W     = $clog2(ENTRIES + 1);
  localparam int KEY_W     = 32;
  localparam int VAL_W     = 32;
  localparam int CAP_W     = 5;
  localparam int IN_W      = KEY_W + VAL_W;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_SET = 1'b1;

  typedef enum logic [1:0] {
    UPD_NONE,
    UPD_HIT,
    UPD_FILL,
    UPD_EVICT
  } upd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_UPDATE
  } state_t;

  typedef struct packed {
    logic capture;
    logic lookup;
    logic commit;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_get;
  } ctrl_stat_t;

endpackage

// ===== rtl/lru_key_value_cache_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_top
// Fully associative key-value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Result: a get result is loaded into the output register after the item is
//   accepted, via capture on accept, parallel lookup and table update.
// Flow: a new item is accepted only once the capture/lookup/update sequence
//   is done; a get waits in update while the output register is still full.
// Reset: synchronous; clears valid bits, ages, fill count, output valid and
//   restores the capacity register to 16. Key and data storage is not cleared.
module lru_key_value_cache_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [lkvc_pkg::CAP_W-1:0]  cfg_data,   // capacity_in_use
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [lkvc_pkg::IN_W-1:0]   s_tdata,    // key[31:0], value[63:32]
  input  logic                        s_tuser,    // command
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [lkvc_pkg::VAL_W-1:0]  m_tdata,    // read_value[31:0]
  output logic                        m_tuser     // hit
);
  import lkvc_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  assign cfg_ready = 1'b1;

  lkvc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lkvc_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input ready right after accepting an item");

  a_miss_reads_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == '0))
    else $error("miss result carries nonzero data");

  a_set_no_result: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == CMD_SET && !m_tvalid) |=> ##2 !$rose(m_tvalid))
    else $error("set item produced a result");

endmodule

// ===== rtl/lkvc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_ctrl
// Request sequencer: capture, lookup, update, and output register handshake.
// ----------------------------------------------------------------------------
module lkvc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  output logic                m_tvalid,
  input  logic                m_tready,
  input  lkvc_pkg::ctrl_stat_t stat,
  output lkvc_pkg::ctrl_cmd_t  cmd
);
  import lkvc_pkg::*;

  state_t state, state_next;
  logic   out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        // a get waits for room in the output register
        if (!(stat.is_get && out_valid && !m_tready)) begin
          cmd.commit   = 1'b1;
          cmd.load_out = stat.is_get;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_tvalid = out_valid;

endmodule

// ===== rtl/lkvc_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_datapath
// Entry table, parallel key match, free/victim select and age update.
// ----------------------------------------------------------------------------
module lkvc_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  lkvc_pkg::ctrl_cmd_t         cmd,
  output lkvc_pkg::ctrl_stat_t        stat,
  input  logic                        cfg_valid,
  input  logic [lkvc_pkg::CAP_W-1:0]  cfg_data,
  input  logic [lkvc_pkg::IN_W-1:0]   s_tdata,
  input  logic                        s_tuser,
  output logic [lkvc_pkg::VAL_W-1:0]  m_tdata,
  output logic                        m_tuser
);
  import lkvc_pkg::*;

  logic [KEY_W-1:0] entry_key  [ENTRIES];
  logic [VAL_W-1:0] entry_data [ENTRIES];
  logic             entry_valid[ENTRIES];
  logic [AGE_W-1:0] entry_age  [ENTRIES];
  logic [CNT_W-1:0] fill_count;
  logic [CAP_W-1:0] capacity;

  logic             req_cmd;
  logic [KEY_W-1:0] req_key;
  logic [VAL_W-1:0] req_value;

  upd_t             upd_kind;
  logic [IDX_W-1:0] upd_idx;
  logic [CNT_W-1:0] upd_thresh;

  logic [VAL_W-1:0] out_value;
  logic             out_hit;

  // lookup logic
  logic             hit_any, free_any;
  logic [IDX_W-1:0] hit_idx, free_idx, victim_idx;
  logic [CNT_W-1:0] eff_cap;
  upd_t             kind_next;
  logic [IDX_W-1:0] idx_next;
  logic [CNT_W-1:0] thresh_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_valid) begin
      capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_cmd   <= s_tuser;
      req_key   <= s_tdata[KEY_W-1:0];
      req_value <= s_tdata[IN_W-1:KEY_W];
    end
  end

  always_comb begin
    if (capacity == '0) begin
      eff_cap = CNT_W'(1);
    end else if (32'(capacity) > 32'(ENTRIES)) begin
      eff_cap = CNT_W'(ENTRIES);
    end else begin
      eff_cap = CNT_W'(capacity);
    end
  end

  always_comb begin
    hit_any    = 1'b0;
    free_any   = 1'b0;
    hit_idx    = '0;
    free_idx   = '0;
    victim_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (entry_valid[i] && entry_key[i] == req_key) begin
        hit_any = 1'b1;
        hit_idx = IDX_W'(i);
      end
      if (!entry_valid[i]) begin
        free_any = 1'b1;
        free_idx = IDX_W'(i);
      end
      // ages form a permutation, the oldest is fill_count - 1
      if (entry_valid[i] && CNT_W'(entry_age[i]) == fill_count - CNT_W'(1)) begin
        victim_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    kind_next   = UPD_NONE;
    idx_next    = hit_idx;
    thresh_next = CNT_W'(entry_age[hit_idx]);
    if (hit_any) begin
      kind_next = UPD_HIT;
    end else if (req_cmd == CMD_SET) begin
      if (fill_count < eff_cap && free_any) begin
        kind_next   = UPD_FILL;
        idx_next    = free_idx;
        thresh_next = fill_count;
      end else begin
        kind_next   = UPD_EVICT;
        idx_next    = victim_idx;
        thresh_next = CNT_W'(entry_age[victim_idx]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upd_kind <= UPD_NONE;
    end else if (cmd.lookup) begin
      upd_kind <= kind_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      upd_idx    <= idx_next;
      upd_thresh <= thresh_next;
    end
  end

  assign stat.is_get = (req_cmd == CMD_GET);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        entry_valid[i] <= 1'b0;
        entry_age[i]   <= '0;
      end
    end else if (cmd.commit && upd_kind != UPD_NONE) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (IDX_W'(i) == upd_idx) begin
          entry_age[i] <= '0;
        end else if (entry_valid[i] && CNT_W'(entry_age[i]) < upd_thresh) begin
          entry_age[i] <= entry_age[i] + AGE_W'(1);
        end
      end
      if (upd_kind == UPD_FILL) begin
        entry_valid[upd_idx] <= 1'b1;
        fill_count           <= fill_count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && req_cmd == CMD_SET) begin
      case (upd_kind)
        UPD_HIT: begin
          entry_data[upd_idx] <= req_value;
        end
        UPD_FILL, UPD_EVICT: begin
          entry_key[upd_idx]  <= req_key;
          entry_data[upd_idx] <= req_value;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_hit   <= (upd_kind == UPD_HIT);
      out_value <= (upd_kind == UPD_HIT) ? entry_data[upd_idx] : '0;
    end
  end

  assign m_tdata = out_value;
  assign m_tuser = out_hit;

endmodule

// ===== bench/tb_lru_key_value_cache_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache_top
// Self-checking bench for the LRU key-value cache. Gets and sets go in on the
// slave stream. A local copy of the table predicts the result of every get,
// and the master stream is checked in order against it. Directed items cover
// extreme keys and values, misses, in-place updates and capacity limits, then
// random traffic over small key pools runs under several capacities and idle
// patterns.
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache_top;
  import lkvc_pkg::*;

  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] value;
  } lookup_result_t;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              cfg_valid = 1'b0;
  logic [CAP_W-1:0]  cfg_data  = '0;
  logic              s_tvalid  = 1'b0;
  logic [IN_W-1:0]   s_tdata   = '0;
  logic              s_tuser   = 1'b0;
  logic              m_tready  = 1'b0;
  logic              cfg_ready;
  logic              s_tready;
  logic              m_tvalid;
  logic [VAL_W-1:0]  m_tdata;
  logic              m_tuser;

  int send_idle  = 0;
  int recv_stall = 0;
  int errors     = 0;

  lookup_result_t expected_reads[$];

  // shadow of the cache table
  logic [KEY_W-1:0] tbl_key   [ENTRIES];
  logic [VAL_W-1:0] tbl_data  [ENTRIES];
  bit               tbl_valid [ENTRIES];
  logic [AGE_W-1:0] tbl_age   [ENTRIES];
  int               tbl_fill;
  logic [CAP_W-1:0] tbl_cap;

  lru_key_value_cache_top u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void table_reset();
    for (int i = 0; i < ENTRIES; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_age[i]   = '0;
      tbl_key[i]   = '0;
      tbl_data[i]  = '0;
    end
    tbl_fill = 0;
    tbl_cap  = CAP_RESET;
  endfunction

  function automatic int effective_capacity(input logic [CAP_W-1:0] cap);
    if (cap == 0) return 1;
    if (cap > ENTRIES) return ENTRIES;
    return int'(cap);
  endfunction

  function automatic void promote(input int idx);
    for (int i = 0; i < ENTRIES; i++)
      if (tbl_valid[i] && i != idx && tbl_age[i] < tbl_age[idx])
        tbl_age[i] = tbl_age[i] + 1'b1;
    tbl_age[idx] = '0;
  endfunction

  function automatic void apply_request(input logic cmd, input logic [KEY_W-1:0] key,
                                        input logic [VAL_W-1:0] val);
    int             hit_idx;
    int             slot;
    int             victim;
    lookup_result_t r;
    hit_idx = -1;
    slot    = -1;
    victim  = -1;
    for (int i = 0; i < ENTRIES; i++)
      if (hit_idx < 0 && tbl_valid[i] && tbl_key[i] == key) hit_idx = i;
    if (cmd == CMD_GET) begin
      if (hit_idx >= 0) begin
        r.hit   = 1'b1;
        r.value = tbl_data[hit_idx];
        promote(hit_idx);
      end else begin
        r.hit   = 1'b0;
        r.value = '0;
      end
      expected_reads.push_back(r);
    end else if (hit_idx >= 0) begin
      tbl_data[hit_idx] = val;
      promote(hit_idx);
    end else begin
      if (tbl_fill < effective_capacity(tbl_cap))
        for (int i = 0; i < ENTRIES; i++)
          if (slot < 0 && !tbl_valid[i]) slot = i;
      if (slot >= 0) begin
        for (int j = 0; j < ENTRIES; j++)
          if (tbl_valid[j]) tbl_age[j] = tbl_age[j] + 1'b1;
        tbl_valid[slot] = 1'b1;
        tbl_key[slot]   = key;
        tbl_data[slot]  = val;
        tbl_age[slot]   = '0;
        tbl_fill++;
      end else begin
        for (int i = 0; i < ENTRIES; i++)
          if (tbl_valid[i] && (victim < 0 || tbl_age[i] > tbl_age[victim])) victim = i;
        if (victim >= 0) begin
          tbl_key[victim]  = key;
          tbl_data[victim] = val;
          promote(victim);
        end
      end
    end
  endfunction

  task automatic send_item(input logic cmd, input logic [KEY_W-1:0] key,
                           input logic [VAL_W-1:0] val);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {val, key};
    do @(posedge clk); while (!s_tready);
    apply_request(cmd, key, val);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_reads.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tbl_cap = cap;
  endtask

  // result checker and receiver backpressure
  always @(posedge clk) begin
    lookup_result_t exp_r;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_reads.size() == 0) begin
          $display("%0t: unexpected result hit=%0d value=%h", $time, m_tuser, m_tdata);
          errors++;
        end else begin
          exp_r = expected_reads.pop_front();
          if (m_tuser !== exp_r.hit) begin
            $display("%0t: hit mismatch expected %0d actual %0d", $time, exp_r.hit, m_tuser);
            errors++;
          end
          if (m_tdata !== exp_r.value) begin
            $display("%0t: read_value mismatch expected %h actual %h",
                     $time, exp_r.value, m_tdata);
            errors++;
          end
        end
      end
      m_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  task automatic test_basic_access();
    send_item(CMD_GET, 32'h0000_0000, 32'h1111_1111);
    send_item(CMD_SET, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(CMD_GET, 32'h8000_0000, 32'h0000_0000);
    send_item(CMD_SET, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(CMD_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_item(CMD_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_item(CMD_SET, 32'h0000_0000, 32'h0000_0000);
    send_item(CMD_GET, 32'h0000_0000, 32'h5555_5555);
    // in-place update of a present key
    send_item(CMD_SET, 32'h8000_0000, 32'h1234_5678);
    send_item(CMD_GET, 32'h8000_0000, 32'h0000_0000);
    send_item(CMD_GET, 32'h0000_0001, 32'h0000_0000);
  endtask

  task automatic test_capacity_limits();
    // capacity below the number already held
    write_capacity(5'd1);
    send_item(CMD_SET, 32'h0000_0001, 32'hA5A5_A5A5);
    send_item(CMD_GET, 32'h0000_0001, 32'h0000_0000);
    send_item(CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    // zero saturates to one
    write_capacity(5'd0);
    send_item(CMD_SET, 32'h0000_0002, 32'h5A5A_5A5A);
    send_item(CMD_GET, 32'h0000_0002, 32'h0000_0000);
    send_item(CMD_GET, 32'h0000_0001, 32'h0000_0000);
    // above table size saturates to the table size
    write_capacity(5'd31);
    send_item(CMD_SET, 32'h0000_0003, 32'hDEAD_BEEF);
    send_item(CMD_SET, 32'h0000_0004, 32'hCAFE_F00D);
    send_item(CMD_GET, 32'h0000_0003, 32'h0000_0000);
    write_capacity(5'd17);
    send_item(CMD_SET, 32'h0000_0005, 32'h0F0F_0F0F);
    send_item(CMD_GET, 32'h0000_0005, 32'h0000_0000);
  endtask

  task automatic test_random_traffic(input int n_items, input int pool_n);
    logic [KEY_W-1:0] pool[$];
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] val;
    logic             cmd;
    for (int i = 0; i < pool_n; i++) begin
      case ($urandom_range(9))
        0:       pool.push_back(32'h8000_0000);
        1:       pool.push_back(32'h7FFF_FFFF);
        default: pool.push_back($urandom);
      endcase
    end
    for (int i = 0; i < n_items; i++) begin
      cmd = ($urandom_range(1) == 1) ? CMD_SET : CMD_GET;
      if ($urandom_range(9) == 0) key = $urandom;
      else key = pool[$urandom_range(pool_n - 1)];
      case ($urandom_range(15))
        0:       val = 32'h8000_0000;
        1:       val = 32'h7FFF_FFFF;
        default: val = $urandom;
      endcase
      send_item(cmd, key, val);
    end
  endtask

  initial begin
    logic [CAP_W-1:0] cap;
    table_reset();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_idle  = 21;
    recv_stall = 76;
    test_basic_access();
    test_capacity_limits();
    write_capacity(5'd16);
    test_random_traffic(100, 20);
    cap = CAP_W'($urandom_range(2, 8));
    write_capacity(cap);
    test_random_traffic(100, effective_capacity(cap) + 3);

    send_idle  = 76;
    recv_stall = 21;
    write_capacity(5'd1);
    test_random_traffic(100, 3);
    write_capacity(5'd31);
    test_random_traffic(100, 20);

    send_idle  = 0;
    recv_stall = 0;
    cap = CAP_W'($urandom_range(0, 31));
    write_capacity(cap);
    test_random_traffic(100, effective_capacity(cap) + 4);
    write_capacity(5'd5);
    test_random_traffic(100, 8);

    wait_drained();
    if (errors == 0) begin
      $display("tb_lru_key_value_cache_top: done, clean");
    end else begin
      $display("tb_lru_key_value_cache_top: done, errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_lru_key_value_cache_top: done, errors");
    $finish;
  end

endmodule
